/* sv/pidl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

  // Number of cells in the chain, one list entry per cell.
  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);

  // Fixed field widths of the channels.
  localparam int OP_W   = 2;
  localparam int POS_W  = 11;
  localparam int LEN_W  = 11;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;

  // The read path ORs the gated cell outputs in groups of this many.
  localparam int GROUP   = 32;
  localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;     // insert: target takes value, cells above shift up
    logic              del;     // delete: target and cells above take right neighbour
    logic [IDX_W-1:0]  tgt;     // zero-based target index
    logic [DATA_W-1:0] value;   // value written by an insert
    logic              rd_en;   // a get is being read out
    logic [IDX_W-1:0]  rd_idx;  // zero-based index of the get
  } cell_ctrl_t;

endpackage

/* sv/pidl_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_req_if
// Request channel: one list operation per transfer.
// ----------------------------------------------------------------------------
interface pidl_req_if;
  logic                              valid;
  logic                              ready;
  logic [pidl_pkg::OP_W-1:0]         op;
  logic [pidl_pkg::POS_W-1:0]        position;
  logic signed [pidl_pkg::DATA_W-1:0] value;

  modport source (output valid, op, position, value, input ready);
  modport sink   (input valid, op, position, value, output ready);
endinterface

/* sv/pidl_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface pidl_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [pidl_pkg::STAT_W-1:0]        status;
  logic signed [pidl_pkg::DATA_W-1:0] read_value;
  logic [pidl_pkg::LEN_W-1:0]         length;

  modport source (output valid, status, read_value, length, input ready);
  modport sink   (input valid, status, read_value, length, output ready);
endinterface

/* sv/positional_insert_delete_list_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list_core
// Ordered list of signed 32-bit values with insert, delete and get by position.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req channel (op, 1-based position, value) and each
//   produces exactly one transfer on the rsp channel (status, read_value,
//   length). Insert accepts positions 1 to length+1, delete and get accept
//   1 to length; anything else reports out of range and changes nothing.
//   An insert at a valid position into a full list reports full.
//   The list lives in a chain of CAPACITY cells. An insert or delete moves
//   every affected entry one cell along in the cycle of the request transfer.
//   A get is gathered through a two-level OR tree whose group level is
//   registered; the read value is registered once more before the response
//   is offered. One request is in flight at a time; req.ready is high only
//   while the core is idle, so a new request is taken only once the last
//   response has gone, and while the receiver stalls the response holds
//   steady on the channel.
//   Reset empties the list (length zero); the cell contents are not cleared,
//   as no entry is read before it has been written.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_core (
  input logic      clk,
  input logic      rst,
  pidl_req_if.sink   req,
  pidl_rsp_if.source rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                          state;
  logic [1:0]                          state_next;
  logic [pidl_pkg::LEN_W-1:0]          count;
  logic [pidl_pkg::LEN_W-1:0]          count_next;
  logic [pidl_pkg::STAT_W-1:0]         status;
  logic [pidl_pkg::STAT_W-1:0]         status_next;
  logic [pidl_pkg::DATA_W-1:0]         read_value;
  logic                                rd_en;
  logic [pidl_pkg::IDX_W-1:0]          rd_idx;

  logic                                acc;
  logic                                pos_nz;
  logic                                ins_pos_ok;
  logic                                acc_pos_ok;
  logic                                full;
  logic                                do_ins;
  logic                                do_del;
  logic                                do_get;
  logic [pidl_pkg::IDX_W-1:0]          tgt;
  pidl_pkg::cell_ctrl_t                ctrl;
  logic [pidl_pkg::DATA_W-1:0]         rd_word;

  logic [pidl_pkg::DATA_W-1:0] entry    [pidl_pkg::CAPACITY];
  logic [pidl_pkg::DATA_W-1:0] left_in  [pidl_pkg::CAPACITY];
  logic [pidl_pkg::DATA_W-1:0] right_in [pidl_pkg::CAPACITY];
  logic [pidl_pkg::DATA_W-1:0] cell_rd  [pidl_pkg::CAPACITY];

  // A request is taken only while nothing else is in flight.
  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;

  // Range checks on the incoming position; the insert check is done in one
  // bit more than the length so that length+1 cannot wrap.
  assign pos_nz     = (req.position != '0);
  assign ins_pos_ok = pos_nz &&
                      ({1'b0, req.position} <= ({1'b0, count} + (pidl_pkg::LEN_W + 1)'(1)));
  assign acc_pos_ok = pos_nz && (req.position <= count);
  assign full       = (count == pidl_pkg::LEN_W'(pidl_pkg::CAPACITY));
  assign tgt        = pidl_pkg::IDX_W'(req.position - pidl_pkg::POS_W'(1));

  assign do_ins = acc && (req.op == pidl_pkg::OP_INSERT) && ins_pos_ok && !full;
  assign do_del = acc && (req.op == pidl_pkg::OP_DELETE) && acc_pos_ok;
  assign do_get = acc && (req.op == pidl_pkg::OP_GET) && acc_pos_ok;

  always_comb begin
    status_next = pidl_pkg::ST_RANGE;
    count_next  = count;
    case (req.op)
      pidl_pkg::OP_INSERT: begin
        if (ins_pos_ok) begin
          if (full) begin
            status_next = pidl_pkg::ST_FULL;
          end else begin
            status_next = pidl_pkg::ST_OK;
            count_next  = count + pidl_pkg::LEN_W'(1);
          end
        end
      end
      pidl_pkg::OP_DELETE: begin
        if (acc_pos_ok) begin
          status_next = pidl_pkg::ST_OK;
          count_next  = count - pidl_pkg::LEN_W'(1);
        end
      end
      pidl_pkg::OP_GET: begin
        if (acc_pos_ok) begin
          status_next = pidl_pkg::ST_OK;
        end
      end
      default: begin
        status_next = pidl_pkg::ST_RANGE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (acc) state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_OUT;
      S_OUT:   if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rd_en <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        count <= count_next;
        rd_en <= do_get;
      end
    end
  end

  // Result payload: status and length are fixed at the request transfer,
  // the read value lands once the OR tree has settled.
  always_ff @(posedge clk) begin
    if (acc) begin
      status <= status_next;
      rd_idx <= tgt;
    end
    if (state == S_RD2) begin
      read_value <= rd_en ? rd_word : '0;
    end
  end

  // Broadcast control for the chain. Shifts happen only on the transfer edge;
  // the read select stays registered for the whole item.
  always_comb begin
    ctrl.ins    = do_ins;
    ctrl.del    = do_del;
    ctrl.tgt    = tgt;
    ctrl.value  = $unsigned(req.value);
    ctrl.rd_en  = rd_en;
    ctrl.rd_idx = rd_idx;
  end

  for (genvar i = 0; i < pidl_pkg::CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = '0;
    end else begin : g_left
      assign left_in[i] = entry[i-1];
    end
    if (i == pidl_pkg::CAPACITY - 1) begin : g_last
      assign right_in[i] = '0;
    end else begin : g_right
      assign right_in[i] = entry[i+1];
    end

    pidl_cell u_cell (
      .clk     (clk),
      .idx     (pidl_pkg::IDX_W'(i)),
      .ctrl    (ctrl),
      .left    (left_in[i]),
      .right   (right_in[i]),
      .entry   (entry[i]),
      .rd_data (cell_rd[i])
    );
  end

  pidl_rd_tree u_rd_tree (
    .clk     (clk),
    .cell_rd (cell_rd),
    .rd_word (rd_word)
  );

  assign rsp.valid      = (state == S_OUT);
  assign rsp.status     = status;
  assign rsp.read_value = $signed(read_value);
  assign rsp.length     = count;

  // The core never takes a request while a response is still offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request taken while a response is pending");

  // The held length never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pidl_pkg::LEN_W'(pidl_pkg::CAPACITY))
    else $error("length beyond capacity");

  // A request transfer closes the request side until its response has gone.
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    acc |=> !req.ready)
    else $error("request side still open after a transfer");

  // A full report only comes from a full list.
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == pidl_pkg::ST_FULL) |->
      (rsp.length == pidl_pkg::LEN_W'(pidl_pkg::CAPACITY)))
    else $error("full reported with room left");

  // A failed operation never returns data.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != pidl_pkg::ST_OK) |-> (rsp.read_value == '0))
    else $error("read value on a failed operation");

endmodule

/* sv/pidl_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_cell
// One list entry; shifts with its neighbours on insert and delete.
// ----------------------------------------------------------------------------
module pidl_cell (
  input  logic                          clk,
  input  logic [pidl_pkg::IDX_W-1:0]    idx,
  input  pidl_pkg::cell_ctrl_t          ctrl,
  input  logic [pidl_pkg::DATA_W-1:0]   left,
  input  logic [pidl_pkg::DATA_W-1:0]   right,
  output logic [pidl_pkg::DATA_W-1:0]   entry,
  output logic [pidl_pkg::DATA_W-1:0]   rd_data
);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (idx == ctrl.tgt) begin
        entry <= ctrl.value;
      end else if (idx > ctrl.tgt) begin
        entry <= left;
      end
    end else if (ctrl.del) begin
      if (idx >= ctrl.tgt) begin
        entry <= right;
      end
    end
  end

  // Only the addressed cell puts its entry on the read path.
  assign rd_data = (ctrl.rd_en && idx == ctrl.rd_idx) ? entry : '0;

endmodule

/* sv/pidl_rd_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_rd_tree
// Registered two-level OR tree that collects the gated cell outputs.
// ----------------------------------------------------------------------------
module pidl_rd_tree (
  input  logic                        clk,
  input  logic [pidl_pkg::DATA_W-1:0] cell_rd [pidl_pkg::CAPACITY],
  output logic [pidl_pkg::DATA_W-1:0] rd_word
);

  logic [pidl_pkg::DATA_W-1:0] group_or [pidl_pkg::NGROUPS];

  for (genvar g = 0; g < pidl_pkg::NGROUPS; g++) begin : g_grp
    logic [pidl_pkg::DATA_W-1:0] acc;
    always_comb begin
      acc = '0;
      for (int k = 0; k < pidl_pkg::GROUP; k++) begin
        if (g * pidl_pkg::GROUP + k < pidl_pkg::CAPACITY) begin
          acc = acc | cell_rd[g * pidl_pkg::GROUP + k];
        end
      end
    end
    always_ff @(posedge clk) begin
      group_or[g] <= acc;
    end
  end

  always_comb begin
    rd_word = '0;
    for (int g = 0; g < pidl_pkg::NGROUPS; g++) begin
      rd_word = rd_word | group_or[g];
    end
  end

endmodule

/* tb/sv/pidl_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_tb_pkg
// Result type and list scoreboard for the positional insert/delete list bench.
// ----------------------------------------------------------------------------
package pidl_tb_pkg;
  import pidl_pkg::*;

  // The fourth op encoding is not used by the core and must change nothing.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] entries[$];
    list_result_t             results[$];
    int unsigned              failures;

    function int unsigned length();
      return entries.size();
    endfunction

    function int unsigned outstanding();
      return results.size();
    endfunction

    // Applies one accepted request to the shadow list and queues its result.
    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] value);
      list_result_t r;
      int unsigned  held;
      int unsigned  idx;
      held         = entries.size();
      idx          = int'(pos) - 1;
      r.status     = ST_RANGE;
      r.read_value = '0;
      case (op)
        OP_INSERT: begin
          if (pos >= 1 && pos <= held + 1) begin
            if (held >= CAPACITY) begin
              r.status = ST_FULL;
            end else begin
              entries.insert(idx, value);
              r.status = ST_OK;
            end
          end
        end
        OP_DELETE: begin
          if (pos >= 1 && pos <= held) begin
            entries.delete(idx);
            r.status = ST_OK;
          end
        end
        OP_GET: begin
          if (pos >= 1 && pos <= held) begin
            r.read_value = entries[idx];
            r.status     = ST_OK;
          end
        end
        default: ;
      endcase
      r.length = LEN_W'(entries.size());
      results.push_back(r);
    endfunction

    // Compares one accepted response with the oldest queued result.
    function void check_response(logic [STAT_W-1:0] status,
                                 logic signed [DATA_W-1:0] read_value,
                                 logic [LEN_W-1:0] length);
      list_result_t want;
      if (results.size() == 0) begin
        $error("response transfer with no request outstanding");
        failures++;
        return;
      end
      want = results.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        failures++;
      end
      if (read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, read_value);
        failures++;
      end
      if (length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, length);
        failures++;
      end
    endfunction
  endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional insert/delete list core.
// ----------------------------------------------------------------------------
// A short directed sequence exercises the edge cases of every operation,
// then random traffic fills the list to capacity and works on it while full.
// Every accepted request is applied to a shadow list held in a queue, and
// every response transfer is checked field by field against the result that
// the shadow list predicts. Both channels idle at random, except during one
// long stretch in which they run flat out.
// ----------------------------------------------------------------------------
module tb_top;
  import pidl_pkg::*;
  import pidl_tb_pkg::*;

  // The slowest correct run stays well under this limit.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Cycles to wait after the last response, a little beyond the core latency.
  localparam int unsigned DRAIN_CYCLES = 10;
  // Number of random transfers made on the list once it has been filled.
  localparam int unsigned FULL_ITEMS   = 24;

  logic        clk;
  logic        rst;
  logic        steady;    // when set, neither side inserts idle cycles
  int unsigned cycles;

  list_scoreboard sb;

  pidl_req_if req_ch ();
  pidl_rsp_if rsp_ch ();

  positional_insert_delete_list_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung core: no correct run comes near this count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Response side. A transfer seen at this edge is checked, then ready is
  // redrawn for the next cycle. Ready is assigned exactly once per edge.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_response(rsp_ch.status, rsp_ch.read_value, rsp_ch.length);
      end
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  // Presents one request, with random idle cycles in front of it unless the
  // bench is in its steady stretch, and waits for the transfer. The request
  // is noted in the scoreboard at the edge on which it is accepted, so the
  // shadow list always reflects every request the core has taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < 31) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.position <= pos;
    req_ch.value    <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(op, pos, value);
  endtask

  // Holds the request side until every outstanding response has arrived.
  task automatic wait_for_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  // Picks a position in 1..top (1 when top is zero), leaning towards the
  // two ends of the list, where the shifting chain has its boundary cases.
  function automatic logic [POS_W-1:0] pick_position(int unsigned top);
    int unsigned roll;
    if (top == 0) return POS_W'(1);
    roll = $urandom_range(0, 9);
    if (roll == 0) return POS_W'(1);
    if (roll == 1) return POS_W'(top);
    return POS_W'($urandom_range(1, top));
  endfunction

  // A request with any op encoding and any position, mostly out of range.
  task automatic send_noise();
    send_request(OP_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 2047)), $urandom());
  endtask

  // One random request. The weights decide how hard the traffic pushes the
  // list towards full; positions are chosen to be valid apart from noise.
  task automatic send_random(input int unsigned ins_pct, input int unsigned get_pct,
                             input int unsigned del_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      send_request(OP_INSERT, pick_position(sb.length() + 1), $urandom());
    end else if (roll < ins_pct + get_pct) begin
      send_request(OP_GET, pick_position(sb.length()), $urandom());
    end else if (roll < ins_pct + get_pct + del_pct) begin
      send_request(OP_DELETE, pick_position(sb.length()), $urandom());
    end else begin
      send_noise();
    end
  endtask

  initial begin
    int unsigned n;
    sb              = new();
    cycles          = 0;
    steady          = 1'b0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.op       <= OP_INSERT;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. On the empty list every operation is out of range,
    // including an insert beyond the append position and at position zero.
    send_request(OP_GET, POS_W'(1), 32'sd0);
    send_request(OP_DELETE, POS_W'(1), 32'sd0);
    send_request(OP_INSERT, POS_W'(0), 32'sd5);
    send_request(OP_INSERT, POS_W'(2), 32'sd5);
    // Build a list of four holding the extreme values: append to empty,
    // append at length+1, insert at the front and insert in the middle.
    send_request(OP_INSERT, POS_W'(1), 32'sh7fff_ffff);
    send_request(OP_INSERT, POS_W'(2), 32'sh8000_0000);
    send_request(OP_INSERT, POS_W'(1), -32'sd1);
    send_request(OP_INSERT, POS_W'(2), 32'sd0);
    send_request(OP_INSERT, POS_W'(6), 32'sd7);
    // Read back every entry, and just past the end and at zero.
    send_request(OP_GET, POS_W'(0), 32'sd0);
    for (int p = 1; p <= 5; p++) send_request(OP_GET, POS_W'(p), $urandom());
    // The unused op code changes nothing, whatever the position.
    send_request(OP_UNUSED, POS_W'(1), 32'sd9);
    // The largest position value is out of range for everything.
    send_request(OP_DELETE, POS_W'(2047), 32'sd0);
    send_request(OP_INSERT, POS_W'(2047), 32'sd0);
    send_request(OP_DELETE, POS_W'(0), 32'sd0);
    // Remove the last entry, then the first, then empty the list.
    send_request(OP_DELETE, POS_W'(4), 32'sd0);
    send_request(OP_DELETE, POS_W'(1), 32'sd0);
    send_request(OP_GET, POS_W'(1), 32'sd0);
    send_request(OP_GET, POS_W'(2), 32'sd0);
    send_request(OP_DELETE, POS_W'(1), 32'sd0);
    send_request(OP_DELETE, POS_W'(1), 32'sd0);

    // The sender holds off here until every response has come back.
    wait_for_responses();

    // Fill the list to capacity with mostly inserts at random positions,
    // mixed with the odd read and delete. A long stretch of this phase runs
    // with no idle cycles on either channel.
    n = 0;
    while (sb.length() < CAPACITY && n < 4 * CAPACITY) begin
      steady = (n >= 200 && n < 400);
      send_random(98, 1, 1);
      n++;
    end
    steady = 1'b0;

    // Pause again, then work on the full list: inserts at valid positions
    // are refused as full, while out-of-range positions still report range.
    wait_for_responses();
    send_request(OP_INSERT, POS_W'(sb.length() + 1), $urandom());
    send_request(OP_INSERT, POS_W'(sb.length() + 2), $urandom());
    send_request(OP_GET, POS_W'(sb.length()), $urandom());
    for (int i = 0; i < FULL_ITEMS; i++) send_random(30, 30, 30);
    req_ch.valid <= 1'b0;

    // Drain the outstanding responses, then allow the core to settle.
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
